FILE: src/asfd_pkg.sv
// Shared constants and types for the addressed status frame deframer.
package asfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 13;

  localparam logic [7:0] START_BYTE   = 8'h21;
  localparam logic [7:0] END_BYTE     = 8'h3B;
  localparam logic [7:0] STATUS_KIND  = 8'hC0;

  // Frame positions of interest
  localparam int POS_STATION   = 1;
  localparam int POS_PHONE     = 2;
  localparam int POS_BOAT_HI   = 3;
  localparam int POS_BOAT_LO   = 4;
  localparam int POS_KIND      = 5;
  localparam int POS_WHEEL     = 6;
  localparam int POS_GEAR      = 7;
  localparam int POS_STATUS    = 8;
  localparam int POS_END       = 9;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHONE_ADDRESS   = 1'd1;

  typedef struct packed {
    logic [7:0] station_address;
    logic [7:0] phone_address;
  } addr_cfg_t;

  typedef struct packed {
    logic [7:0] boat_address_high;
    logic [7:0] boat_address_low;
    logic [7:0] wheel_status;
    logic [7:0] gear_status;
    logic [7:0] boat_status;
  } frame_result_t;

endpackage

FILE: src/asfd_frame.sv
// Frame tracker: position counter, length flag, held frame bytes and close check.
module asfd_frame #(
  parameter int MAX_FRAME_BYTES = asfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  input  asfd_pkg::addr_cfg_t     cfg,
  output logic                    hit,
  output asfd_pkg::frame_result_t result
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);

  logic             receiving_r, receiving_nxt;
  logic             len_known_r, len_known_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       b1_r, b2_r, b3_r, b4_r, b6_r, b7_r, b8_r;
  logic             is_start, is_close;

  assign pos_inc  = pos_r + POS_W'(1);
  assign is_start = (rx_byte == asfd_pkg::START_BYTE) && !receiving_r;
  assign is_close = (rx_byte == asfd_pkg::END_BYTE) && receiving_r && len_known_r &&
                    (pos_r == POS_W'(asfd_pkg::POS_END));

  // Byte zero and the kind byte are fixed once the length is known.
  assign hit = is_close && (b1_r == cfg.station_address) && (b2_r == cfg.phone_address);

  assign result.boat_address_high = b3_r;
  assign result.boat_address_low  = b4_r;
  assign result.wheel_status      = b6_r;
  assign result.gear_status       = b7_r;
  assign result.boat_status       = b8_r;

  always_comb begin
    receiving_nxt = receiving_r;
    len_known_nxt = len_known_r;
    pos_nxt       = pos_r;
    if (is_start) begin
      receiving_nxt = 1'b1;
      len_known_nxt = 1'b0;
      pos_nxt       = POS_W'(1);
    end else if (is_close) begin
      receiving_nxt = 1'b0;
      len_known_nxt = 1'b0;
      pos_nxt       = '0;
    end else if (receiving_r) begin
      pos_nxt = pos_inc;
      if (pos_r == POS_W'(asfd_pkg::POS_KIND) && rx_byte == asfd_pkg::STATUS_KIND) begin
        len_known_nxt = 1'b1;
      end
      if ((pos_r == POS_W'(asfd_pkg::POS_STATION) && rx_byte != cfg.station_address) ||
          (pos_inc >= POS_LIMIT)) begin
        receiving_nxt = 1'b0;
        len_known_nxt = 1'b0;
        pos_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      len_known_r <= 1'b0;
      pos_r       <= '0;
    end else if (step) begin
      receiving_r <= receiving_nxt;
      len_known_r <= len_known_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Hold frame bytes; they are always rewritten before a close can read them.
  always_ff @(posedge clk) begin
    if (step && receiving_r && !is_close) begin
      case (pos_r)
        POS_W'(asfd_pkg::POS_STATION): b1_r <= rx_byte;
        POS_W'(asfd_pkg::POS_PHONE):   b2_r <= rx_byte;
        POS_W'(asfd_pkg::POS_BOAT_HI): b3_r <= rx_byte;
        POS_W'(asfd_pkg::POS_BOAT_LO): b4_r <= rx_byte;
        POS_W'(asfd_pkg::POS_WHEEL):   b6_r <= rx_byte;
        POS_W'(asfd_pkg::POS_GEAR):    b7_r <= rx_byte;
        POS_W'(asfd_pkg::POS_STATUS):  b8_r <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/asfd_outreg.sv
// Result holding register with valid/ready towards the consumer.
module asfd_outreg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  asfd_pkg::frame_result_t load_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output asfd_pkg::frame_result_t out_data
);

  logic                    valid_r, valid_nxt;
  asfd_pkg::frame_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: src/addressed_status_frame_deframer.sv
// Top level of the addressed status frame deframer: input stage, config, tracker, result.
//
//  channel | direction | beat carries                          | handshake
//  --------+-----------+---------------------------------------+-------------------
//  in_     | in        | rx_byte                               | in_valid/in_ready
//  out_    | out       | boat address hi/lo, wheel, gear, boat | out_valid/out_ready
//  cfg_    | in        | cfg_index, cfg_data                   | cfg_valid/cfg_ready
//
// A byte beat lands in the input register and is judged by the frame tracker when it
// advances out of that register; if it closes a matching frame the result is loaded into the
// output register as the byte advances, so out_valid rises after the input register; one
// byte is taken per cycle while the consumer does not stall.
// The input register advances whenever the output register is empty or being taken;
// a stalled consumer holds the input stage and so the input channel.
// Reset (synchronous, rst_n low) returns the tracker to idle and clears both
// address registers; configuration writes are taken in every cycle.
module addressed_status_frame_deframer #(
  parameter int MAX_FRAME_BYTES = asfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_boat_address_high,
  output logic [7:0]                     out_boat_address_low,
  output logic [7:0]                     out_wheel_status,
  output logic [7:0]                     out_gear_status,
  output logic [7:0]                     out_boat_status,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [asfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic                    in_valid_r, in_valid_nxt;
  logic [7:0]              in_byte_r;
  logic                    advance;
  logic                    hit;
  asfd_pkg::addr_cfg_t     cfg_r;
  asfd_pkg::frame_result_t result;
  asfd_pkg::frame_result_t out_data;

  // Advance the held byte only when the result register can take a beat.
  assign advance  = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Address registers: always ready, written on the index given.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        asfd_pkg::REG_STATION_ADDRESS: cfg_r.station_address <= cfg_data;
        asfd_pkg::REG_PHONE_ADDRESS:   cfg_r.phone_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  asfd_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .hit     (hit),
    .result  (result)
  );

  asfd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && hit),
    .load_data (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_boat_address_high = out_data.boat_address_high;
  assign out_boat_address_low  = out_data.boat_address_low;
  assign out_wheel_status      = out_data.wheel_status;
  assign out_gear_status       = out_data.gear_status;
  assign out_boat_status       = out_data.boat_status;

endmodule

FILE: tb/tb_addressed_status_frame_deframer.sv
// Self-checking testbench for the addressed status frame deframer.
`timescale 1ns / 1ps

module tb_addressed_status_frame_deframer;

  localparam int FRAME_CAP      = asfd_pkg::MAX_FRAME_BYTES_DEF;
  localparam logic [3:0] STATUS_FRAME_LEN = 4'd10;
  localparam int SETTLE_CYCLES  = 4;      // idle time that lets the pipeline run dry
  localparam int RANDOM_BEATS   = 860;
  localparam int PHASE_BEATS    = 110;
  localparam int CYCLE_LIMIT    = 200000;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  // How the expectation of a byte row is formed: from the predictor, none at all,
  // or a result typed into the table.
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} row_check_t;

  typedef struct {
    row_kind_t                       kind;
    logic [asfd_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [7:0]                      value;
    row_check_t                      check;
    asfd_pkg::frame_result_t         typed;
  } stim_row_t;

  // Block ports; every input starts at a known value.
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_rx_byte = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_boat_address_high;
  logic [7:0]                     out_boat_address_low;
  logic [7:0]                     out_wheel_status;
  logic [7:0]                     out_gear_status;
  logic [7:0]                     out_boat_status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [asfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  // Shadow copy of the deframer: address registers and frame tracker.
  logic [7:0]    cur_station = '0;
  logic [7:0]    cur_phone = '0;
  bit            rx_open;
  int            rx_pos;
  logic [3:0]    rx_len;
  logic [7:0]    rx_store [FRAME_CAP];

  asfd_pkg::frame_result_t pending_reports [$];   // status reports still owed by the block
  stim_row_t               script [$];            // directed stimulus table
  int unsigned             sent_beats = 0;        // byte beats taken by the block
  int unsigned             err_count = 0;
  int unsigned             cycle_count = 0;
  int unsigned             out_hold = 0;
  int unsigned             out_draw = 0;
  bit                      calm_in = 1'b0;        // sender never pauses while set
  bit                      calm_out = 1'b0;       // receiver never stalls while set
  asfd_pkg::frame_result_t seen;
  asfd_pkg::frame_result_t want;

  addressed_status_frame_deframer u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_boat_address_high (out_boat_address_high),
    .out_boat_address_low  (out_boat_address_low),
    .out_wheel_status      (out_wheel_status),
    .out_gear_status       (out_gear_status),
    .out_boat_status       (out_boat_status),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abandon the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracker prediction
  // ---------------------------------------------------------------------------

  // Drop the frame in progress and return to idle.
  function automatic void clear_frame();
    rx_open = 1'b0;
    rx_pos  = 0;
    rx_len  = '0;
    foreach (rx_store[k]) rx_store[k] = '0;
  endfunction

  // Advance the tracker by one received byte; return 1 when it closes a frame
  // addressed to this station from the expected phone.
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output asfd_pkg::frame_result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (b == asfd_pkg::START_BYTE && !rx_open) begin
      clear_frame();
      rx_open = 1'b1;
    end else if (b == asfd_pkg::END_BYTE && rx_open && rx_pos + 1 == int'(rx_len)) begin
      if (rx_pos < FRAME_CAP) rx_store[rx_pos] = b;
      // Addresses are judged against the registers as they stand at the close.
      if (rx_store[0] == asfd_pkg::START_BYTE &&
          rx_store[asfd_pkg::POS_STATION] == cur_station &&
          rx_store[asfd_pkg::POS_PHONE] == cur_phone &&
          rx_store[asfd_pkg::POS_KIND] == asfd_pkg::STATUS_KIND &&
          rx_store[asfd_pkg::POS_END] == asfd_pkg::END_BYTE) begin
        res.boat_address_high = rx_store[asfd_pkg::POS_BOAT_HI];
        res.boat_address_low  = rx_store[asfd_pkg::POS_BOAT_LO];
        res.wheel_status      = rx_store[asfd_pkg::POS_WHEEL];
        res.gear_status       = rx_store[asfd_pkg::POS_GEAR];
        res.boat_status       = rx_store[asfd_pkg::POS_STATUS];
        hit = 1'b1;
      end
      clear_frame();
    end
    if (rx_open) begin
      if (rx_pos < FRAME_CAP) rx_store[rx_pos] = b;
      rx_pos++;
      if (rx_pos == asfd_pkg::POS_STATION + 1) begin
        if (rx_store[asfd_pkg::POS_STATION] != cur_station) clear_frame();
      end else if (rx_pos == asfd_pkg::POS_KIND + 1) begin
        if (rx_store[asfd_pkg::POS_KIND] == asfd_pkg::STATUS_KIND) rx_len = STATUS_FRAME_LEN;
      end
      // A frame that fills the store without closing is dropped.
      if (rx_pos >= FRAME_CAP) clear_frame();
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table construction
  // ---------------------------------------------------------------------------

  // Append n bytes, first byte in the most significant position of seq.
  function automatic void put_bytes(input logic [8*12-1:0] seq, input int n);
    stim_row_t row;
    row = '{ROW_BYTE, '0, '0, CHK_PREDICT, '0};
    for (int k = 0; k < n; k++) begin
      row.value = seq[8*(n-1-k) +: 8];
      script.push_back(row);
    end
  endfunction

  function automatic void put_close(input row_check_t chk,
                                    input asfd_pkg::frame_result_t res);
    script.push_back('{ROW_BYTE, '0, asfd_pkg::END_BYTE, chk, res});
  endfunction

  function automatic void put_cfg(input logic [asfd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] v);
    script.push_back('{ROW_CFG, idx, v, CHK_NONE, '0});
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Random byte, biased towards the framing codes and the extremes.
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 11))
      0:       return asfd_pkg::START_BYTE;
      1:       return asfd_pkg::END_BYTE;
      2:       return asfd_pkg::STATUS_KIND;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Offer one byte beat, hold it until taken, then log what it should produce.
  task automatic send_byte(input logic [7:0] b, input row_check_t chk,
                           input asfd_pkg::frame_result_t typed);
    int unsigned             gap;
    asfd_pkg::frame_result_t res;
    bit                      hit;
    gap = calm_in ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_beats++;
    hit = deframe_byte(b, res);
    if (chk == CHK_TYPED) pending_reports.push_back(typed);
    else if (chk == CHK_PREDICT && hit) pending_reports.push_back(res);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no gap; the caller drops it.
  task automatic write_reg(input logic [asfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == asfd_pkg::REG_STATION_ADDRESS) cur_station = v;
    else cur_phone = v;
  endtask

  // Hold the input idle until every owed report has arrived, then let the
  // pipeline empty so bytes that close nothing are fully absorbed.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random burst of traffic: mostly well-formed frames with random content,
  // some line noise and some frames that break off or run away.
  task automatic send_sequence();
    int unsigned shape;
    int unsigned n;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(noisy_byte(), CHK_PREDICT, '0);
    end else if (shape == 1) begin
      send_byte(asfd_pkg::START_BYTE, CHK_PREDICT, '0);
      n = $urandom_range(1, 14);
      repeat (n) send_byte(noisy_byte(), CHK_PREDICT, '0);
    end else begin
      send_byte(asfd_pkg::START_BYTE, CHK_PREDICT, '0);
      send_byte(chance(95) ? cur_station : noisy_byte(), CHK_PREDICT, '0);
      send_byte(chance(85) ? cur_phone : noisy_byte(), CHK_PREDICT, '0);
      repeat (2) send_byte(noisy_byte(), CHK_PREDICT, '0);
      send_byte(chance(85) ? asfd_pkg::STATUS_KIND : noisy_byte(), CHK_PREDICT, '0);
      repeat (3) send_byte(noisy_byte(), CHK_PREDICT, '0);
      if (chance(85)) begin
        send_byte(asfd_pkg::END_BYTE, CHK_PREDICT, '0);
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(noisy_byte(), CHK_PREDICT, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and field-by-field comparison
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = '{out_boat_address_high, out_boat_address_low, out_wheel_status,
                 out_gear_status, out_boat_status};
        if (pending_reports.size() == 0) begin
          $error("status report 0x%010h arrived with nothing expected", seen);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("boat_address_high", want.boat_address_high, seen.boat_address_high);
          check_field("boat_address_low", want.boat_address_low, seen.boat_address_low);
          check_field("wheel_status", want.wheel_status, seen.wheel_status);
          check_field("gear_status", want.gear_status, seen.gear_status);
          check_field("boat_status", want.boat_status, seen.boat_status);
        end
        // Draw the stall for the next beat; keep ready high when there is none.
        out_draw = calm_out ? 0 : $urandom_range(0, 8);
        if (out_draw != 0) begin
          out_ready <= 1'b0;
          out_hold  <= out_draw - 1;
        end
      end else if (!out_ready) begin
        if (out_hold == 0) out_ready <= 1'b1;
        else out_hold <= out_hold - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned phase;
    int unsigned goal;
    int unsigned phase_goal;
    logic [7:0]  st;
    logic [7:0]  ph;

    clear_frame();

    // Directed table.
    // Stray end byte while idle: ignore it.
    put_bytes({asfd_pkg::END_BYTE}, 1);
    // Addresses straight after reset are zero; all-ones status bytes.
    put_bytes({8'h21, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hC0, 8'hFF, 8'hFF, 8'hFF}, 9);
    put_close(CHK_TYPED, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    put_cfg(asfd_pkg::REG_STATION_ADDRESS, 8'hFF);
    put_cfg(asfd_pkg::REG_PHONE_ADDRESS, 8'hA5);
    // Wrong station at byte one: drop the frame.
    put_bytes({8'h21, 8'h00}, 2);
    // Start byte and an early end byte inside the frame are plain data.
    put_bytes({8'h21, 8'hFF, 8'hA5, 8'h21, 8'h3B, 8'hC0, 8'h00, 8'h00, 8'h00}, 9);
    put_close(CHK_TYPED, '{8'h21, 8'h3B, 8'h00, 8'h00, 8'h00});
    // Phone address changed while a frame is open: the close no longer matches.
    put_bytes({8'h21, 8'hFF, 8'hA5, 8'h00, 8'h00, 8'hC0}, 6);
    put_cfg(asfd_pkg::REG_PHONE_ADDRESS, 8'h5A);
    put_bytes({8'h00, 8'h00, 8'h00}, 3);
    put_close(CHK_NONE, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (i == 0 || script[i-1].kind != ROW_CFG) settle();
        write_reg(script[i].reg_idx, script[i].value);
        if (i == script.size() - 1 || script[i+1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        send_byte(script[i].value, script[i].check, script[i].typed);
      end
    end

    // Random phases: each one drains, picks new addresses and idling pattern.
    goal  = sent_beats + RANDOM_BEATS;
    phase = 0;
    while (sent_beats < goal) begin
      settle();
      case (phase)
        0: begin st = 8'h00; ph = 8'hFF; end
        1: begin st = 8'hFF; ph = 8'h00; end
        default: begin st = 8'($urandom()); ph = 8'($urandom()); end
      endcase
      write_reg(asfd_pkg::REG_STATION_ADDRESS, st);
      write_reg(asfd_pkg::REG_PHONE_ADDRESS, ph);
      cfg_valid <= 1'b0;
      calm_in  = (phase % 4 == 1) || (phase % 4 == 3);
      calm_out = (phase % 4 == 2) || (phase % 4 == 3);
      phase_goal = sent_beats + PHASE_BEATS;
      while (sent_beats < phase_goal) send_sequence();
      phase++;
    end

    // Wait for the last reports and let the pipeline run dry.
    settle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
